[hdl/pmpd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; used by every module of the block.
package pmpd_pkg;

  // Result item kinds
  typedef enum logic [2:0] {
    EV_DONE   = 3'd0,
    EV_LEFT   = 3'd1,
    EV_RIGHT  = 3'd2,
    EV_MIDDLE = 3'd3,
    EV_MOVE   = 3'd4
  } event_kind_t;

  // Header byte layout
  localparam int unsigned BIT_LEFT    = 0;
  localparam int unsigned BIT_RIGHT   = 1;
  localparam int unsigned BIT_MIDDLE  = 2;
  localparam int unsigned BIT_X_SIGN  = 4;
  localparam int unsigned BIT_Y_SIGN  = 5;
  localparam logic [7:0]  SYNC_MASK   = 8'h08;
  localparam logic [7:0]  Y_SIGN_MASK = 8'h20;

  // Packet slots run 0..2
  localparam logic [1:0] LAST_SLOT = 2'd2;

  // Decoded work for one accepted byte, passed from front to back
  typedef struct packed {
    logic       ev_left;
    logic       ev_right;
    logic       ev_middle;
    logic       ev_move;
    logic       left_lvl;
    logic       right_lvl;
    logic       middle_lvl;
    logic [8:0] dx;
    logic [9:0] dy;
    logic       recognized;
  } job_t;

endpackage

[hdl/pmpd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts controller bytes, assembles packets, detects button changes.
// Depends on pmpd_pkg.
module pmpd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,   // data_byte[7:0], consumer_connected[8], zero pad
  input  logic [0:0]     s_tuser,   // from_mouse[0]
  output logic           job_valid,
  input  logic           job_ready,
  output pmpd_pkg::job_t job
);

  logic [1:0] pos;
  logic [7:0] head_byte;
  logic [7:0] x_byte;
  logic       left_lvl;
  logic       right_lvl;
  logic       middle_lvl;

  logic       mouse;
  logic [7:0] din;
  logic       consumer;
  logic [1:0] slot;
  logic       take;
  logic       complete;
  logic       fire;
  logic       accept;
  logic [8:0] dx;
  logic [8:0] dy9;
  logic [9:0] dy_neg;
  logic [1:0] pos_next;

  assign mouse     = s_tuser[0];
  assign din       = s_tdata[7:0];
  assign consumer  = s_tdata[8];
  assign s_tready  = job_ready;
  assign job_valid = s_tvalid;
  assign accept    = s_tvalid && job_ready;

  always_comb begin
    slot     = (pos > pmpd_pkg::LAST_SLOT) ? 2'd0 : pos;
    take     = mouse && ((slot != 2'd0) || ((din & pmpd_pkg::SYNC_MASK) != 8'h00));
    complete = take && (slot == pmpd_pkg::LAST_SLOT);
    fire     = complete && consumer;
    dx       = {head_byte[pmpd_pkg::BIT_X_SIGN], x_byte};
    dy9      = {((head_byte & pmpd_pkg::Y_SIGN_MASK) != 8'h00), din};
    dy_neg   = 10'd0 - {dy9[8], dy9};

    if (!take) begin
      pos_next = pos;
    end else if (complete) begin
      pos_next = 2'd0;
    end else begin
      pos_next = slot + 2'd1;
    end

    job.ev_left    = fire && (head_byte[pmpd_pkg::BIT_LEFT] != left_lvl);
    job.ev_right   = fire && (head_byte[pmpd_pkg::BIT_RIGHT] != right_lvl);
    job.ev_middle  = fire && (head_byte[pmpd_pkg::BIT_MIDDLE] != middle_lvl);
    job.ev_move    = fire && ((dx != 9'd0) || (dy9 != 9'd0));
    job.left_lvl   = head_byte[pmpd_pkg::BIT_LEFT];
    job.right_lvl  = head_byte[pmpd_pkg::BIT_RIGHT];
    job.middle_lvl = head_byte[pmpd_pkg::BIT_MIDDLE];
    job.dx         = job.ev_move ? dx : 9'd0;
    job.dy         = job.ev_move ? dy_neg : 10'd0;
    job.recognized = mouse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 2'd0;
      left_lvl   <= 1'b0;
      right_lvl  <= 1'b0;
      middle_lvl <= 1'b0;
    end else if (accept) begin
      pos <= pos_next;
      if (fire) begin
        left_lvl   <= head_byte[pmpd_pkg::BIT_LEFT];
        right_lvl  <= head_byte[pmpd_pkg::BIT_RIGHT];
        middle_lvl <= head_byte[pmpd_pkg::BIT_MIDDLE];
      end
    end
  end

  // Packet byte store: header and X only, Y is used as it arrives
  always_ff @(posedge clk) begin
    if (accept && take) begin
      if (slot == 2'd0) begin
        head_byte <= din;
      end
      if (slot == 2'd1) begin
        x_byte <= din;
      end
    end
  end

endmodule

[hdl/pmpd_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of decoded jobs between front and back end.
// Depends on pmpd_pkg.
module pmpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pmpd_pkg::job_t push_job,
  output logic           head_valid,
  input  logic           pop,
  output pmpd_pkg::job_t head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pmpd_pkg::job_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign push       = push_valid && push_ready;
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

[hdl/pmpd_back.sv]
`timescale 1ns / 1ps
// Back end: expands one job into its result items through an output register.
// Depends on pmpd_pkg.
module pmpd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  pmpd_pkg::job_t job,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,   // button_level[0], delta_x[9:1], delta_y[19:10],
                                    // recognized[20], zero pad
  output logic [2:0]     m_tuser,   // event_kind[2:0]
  output logic           m_tlast    // last_result
);

  logic [3:0]            sent;
  logic [3:0]            pending;
  logic [3:0]            pick;
  logic                  load;
  pmpd_pkg::event_kind_t kind;
  logic                  level;

  assign load    = !m_tvalid || m_tready;
  assign pending = {job.ev_move, job.ev_middle, job.ev_right, job.ev_left} & ~sent;
  assign pop     = load && job_valid && (kind == pmpd_pkg::EV_DONE);

  // Emit events in order left, right, middle, move, then done
  always_comb begin
    kind  = pmpd_pkg::EV_DONE;
    pick  = 4'b0000;
    level = 1'b0;
    if (pending[0]) begin
      kind  = pmpd_pkg::EV_LEFT;
      pick  = 4'b0001;
      level = job.left_lvl;
    end else if (pending[1]) begin
      kind  = pmpd_pkg::EV_RIGHT;
      pick  = 4'b0010;
      level = job.right_lvl;
    end else if (pending[2]) begin
      kind  = pmpd_pkg::EV_MIDDLE;
      pick  = 4'b0100;
      level = job.middle_lvl;
    end else if (pending[3]) begin
      kind  = pmpd_pkg::EV_MOVE;
      pick  = 4'b1000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sent     <= 4'b0000;
    end else if (load) begin
      m_tvalid <= job_valid;
      if (job_valid) begin
        sent <= (kind == pmpd_pkg::EV_DONE) ? 4'b0000 : (sent | pick);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      m_tuser <= kind;
      m_tlast <= (kind == pmpd_pkg::EV_DONE);
      m_tdata <= {3'b000,
                  (kind == pmpd_pkg::EV_DONE) && job.recognized,
                  (kind == pmpd_pkg::EV_MOVE) ? job.dy : 10'd0,
                  (kind == pmpd_pkg::EV_MOVE) ? job.dx : 9'd0,
                  level};
    end
  end

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == pmpd_pkg::EV_DONE)))
    else $error("last flag and done kind disagree");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (sent != 4'b0000) |-> job_valid)
    else $error("job left the queue while its events were in flight");

  a_no_delta_off_move: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != pmpd_pkg::EV_MOVE)) |-> (m_tdata[19:1] == 19'd0))
    else $error("movement data on a non-move item");

  a_sent_clears: assert property (@(posedge clk) disable iff (rst)
    pop |=> (sent == 4'b0000))
    else $error("event mask not cleared after job retired");

endmodule

[hdl/ps2_mouse_packet_decoder_top.sv]
`timescale 1ns / 1ps
// Top level of the PS/2 mouse three-byte packet decoder.
// Depends on pmpd_pkg, pmpd_front, pmpd_queue and pmpd_back.
//
// Usage:
//   Input stream (s_*): one controller byte per request. s_tuser[0] marks the
//   byte as mouse data, s_tdata[7:0] is the byte, s_tdata[8] says whether an
//   event consumer is attached. Mouse bytes build standard three-byte packets;
//   a header byte without its always-one bit is dropped to regain sync.
//   Output stream (m_*): for each accepted byte, zero to four events (button
//   changes left, right, middle, then a move) followed by one done item that
//   carries m_tlast. m_tuser is the event kind.
// Data path and throughput:
//   The first result of a byte passes through the job queue and then the output
//   register. The output register delivers one item per cycle while m_tready is
//   high; each byte yields one item plus one per event, up to 5 items on a full packet.
//   The front accepts a byte every cycle while the job queue has room.
// Reset:
//   rst (synchronous, active high) empties the queue, drops any item in the
//   output register, returns to packet slot 0 and clears all button levels.
// Stalls:
//   When m_tready is low the output item holds; the queue then fills and
//   s_tready drops once QUEUE_DEPTH jobs are waiting.
module ps2_mouse_packet_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], consumer_connected[8], zero pad
  input  logic [0:0]  s_tuser,   // from_mouse[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // button_level[0], delta_x[9:1], delta_y[19:10],
                                 // recognized[20], zero pad
  output logic [2:0]  m_tuser,   // event_kind[2:0]
  output logic        m_tlast    // last_result
);

  pmpd_pkg::job_t front_job;
  pmpd_pkg::job_t head_job;
  logic           front_valid;
  logic           queue_ready;
  logic           head_valid;
  logic           pop;

  // Classify bytes and track packet/button state
  pmpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (front_valid),
    .job_ready (queue_ready),
    .job       (front_job)
  );

  // Decouple byte intake from item delivery
  pmpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_job   (front_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  // Expand each job into events plus the closing done item
  pmpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
